// ===== rtl/stt_pkg.sv =====
package stt_pkg;

	localparam int FIELD_BITS = 20;
	localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;
	localparam logic [FIELD_BITS-1:0] FIRST_LINE_RESET = 20'd1;

	typedef logic [4:0] kind_t;

	localparam kind_t KIND_EOF        = 5'd0;
	localparam kind_t KIND_PUNCT_BASE = 5'd1;
	localparam kind_t KIND_GT         = 5'd14;
	localparam kind_t KIND_GE         = 5'd15;
	localparam kind_t KIND_LT         = 5'd16;
	localparam kind_t KIND_LE         = 5'd17;
	localparam kind_t KIND_INT        = 5'd18;
	localparam kind_t KIND_FLOAT      = 5'd19;
	localparam kind_t KIND_IDENT      = 5'd20;
	localparam kind_t KIND_KW_BASE    = 5'd21;
	localparam kind_t KIND_ERROR      = 5'd31;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;

	localparam int NUM_PUNCT = 13;
	localparam logic [7:0] PUNCT_CHARS [NUM_PUNCT] = '{
		8'h2B, 8'h2D, 8'h2F, 8'h2A, 8'h3D, 8'h2C, 8'h3B,
		8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D
	};

	// Keywords are packed with the first letter in the lowest byte, hence the
	// reversed spelling of each string.
	localparam int NUM_KEYWORDS = 10;
	localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
		64'("rav"), 64'("tel"), 64'("eurt"), 64'("eslaf"), 64'("fi"),
		64'("neht"), 64'("esle"), 64'("taolf"), 64'("regetni"), 64'("loob")
	};
	localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
		4'd3, 4'd3, 4'd4, 4'd5, 4'd2, 4'd4, 4'd4, 4'd5, 4'd7, 4'd4
	};

	typedef struct packed {
		kind_t                 kind;
		logic [FIELD_BITS-1:0] start;
		logic [FIELD_BITS-1:0] length;
		logic [FIELD_BITS-1:0] line;
		logic                  last;
	} token_t;

	// Up to two tokens from one word, first one in slot a.
	typedef struct packed {
		logic   a_valid;
		token_t a;
		logic   b_valid;
		token_t b;
	} tok_pair_t;

	function automatic logic is_digit(logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic [FIELD_BITS-1:0] clamp_field(logic [32:0] v);
		return (v > 33'(FIELD_MAX)) ? FIELD_MAX : v[FIELD_BITS-1:0];
	endfunction

endpackage

// ===== rtl/stt_scan.sv =====
module stt_scan import stt_pkg::*; #(
	parameter int POSITION_BITS = 20,
	parameter int KEYWORD_CHARS = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [FIELD_BITS-1:0] cfg_first_line,
	input  logic                  fire,
	input  logic [7:0]            char_s1,
	input  logic                  eot_s1,
	output tok_pair_t             pair
);

	localparam int WORD_BITS = 8 * KEYWORD_CHARS;
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	typedef enum logic [2:0] {
		M_IDLE, M_NUMBER, M_AFTER_DOT, M_FRACTION, M_WORD, M_GT, M_LT, M_COMMENT
	} mode_t;

	mode_t                    mode_q, mode_d;
	logic [POSITION_BITS-1:0] pos_q, start_q, start_d;
	logic [FIELD_BITS-1:0]    line_q;
	logic [WORD_BITS-1:0]     wbuf_q, wbuf_d;
	logic [3:0]               wlen_q, wlen_d;

	logic [POSITION_BITS-1:0] len_before;
	kind_t                    word_kind;

	// Handling of a byte seen between tokens.
	logic  id_tok;
	kind_t id_kind;
	mode_t id_mode;
	logic  id_line;
	logic  id_word;

	logic        fin_v, sec_v, use_idle, line_inc, pos_inc;
	kind_t       fin_kind, sec_kind;
	logic [32:0] fin_len;
	logic [32:0] sec_len;

	assign len_before = pos_q - start_q;

	always_comb begin
		word_kind = KIND_IDENT;
		for (int k = 0; k < NUM_KEYWORDS; k++) begin
			if (wlen_q == KW_LEN[k] && 64'(wbuf_q) == KW_TEXT[k]) begin
				word_kind = KIND_KW_BASE + 5'(k);
			end
		end
	end

	always_comb begin
		id_tok  = 1'b0;
		id_kind = KIND_ERROR;
		id_mode = M_IDLE;
		id_line = 1'b0;
		id_word = 1'b0;
		priority if (char_s1 == CH_SPACE || char_s1 == CH_TAB || char_s1 == CH_CR) begin
			id_mode = M_IDLE;
		end else if (char_s1 == CH_LF) begin
			id_line = 1'b1;
		end else if (char_s1 == CH_HASH) begin
			id_mode = M_COMMENT;
		end else if (char_s1 == CH_NUL) begin
			id_tok  = 1'b1;
			id_kind = KIND_EOF;
		end else if (char_s1 == CH_GT) begin
			id_mode = M_GT;
		end else if (char_s1 == CH_LT) begin
			id_mode = M_LT;
		end else if (is_digit(char_s1)) begin
			id_mode = M_NUMBER;
		end else if (is_letter(char_s1)) begin
			id_mode = M_WORD;
			id_word = 1'b1;
		end else begin
			id_tok = 1'b1;
			for (int k = 0; k < NUM_PUNCT; k++) begin
				if (char_s1 == PUNCT_CHARS[k]) begin
					id_kind = KIND_PUNCT_BASE + 5'(k);
				end
			end
		end
	end

	always_comb begin
		mode_d   = mode_q;
		start_d  = start_q;
		wbuf_d   = wbuf_q;
		wlen_d   = wlen_q;
		fin_v    = 1'b0;
		fin_kind = KIND_INT;
		fin_len  = 33'(len_before);
		sec_v    = 1'b0;
		sec_kind = KIND_EOF;
		sec_len  = 33'd0;
		use_idle = 1'b0;
		line_inc = 1'b0;
		pos_inc  = 1'b0;
		if (eot_s1) begin
			unique case (mode_q)
				M_NUMBER, M_AFTER_DOT: begin
					fin_v    = 1'b1;
					fin_kind = KIND_INT;
				end
				M_FRACTION: begin
					fin_v    = 1'b1;
					fin_kind = KIND_FLOAT;
				end
				M_WORD: begin
					fin_v    = 1'b1;
					fin_kind = word_kind;
				end
				M_GT: begin
					fin_v    = 1'b1;
					fin_kind = KIND_GT;
				end
				M_LT: begin
					fin_v    = 1'b1;
					fin_kind = KIND_LT;
				end
				default: begin
					fin_v = 1'b0;
				end
			endcase
			mode_d  = M_IDLE;
			start_d = pos_q;
			sec_v   = 1'b1;
		end else begin
			pos_inc = 1'b1;
			unique case (mode_q)
				M_COMMENT: begin
					if (char_s1 == CH_LF) begin
						line_inc = 1'b1;
						mode_d   = M_IDLE;
					end
				end
				M_GT, M_LT: begin
					fin_v = 1'b1;
					if (char_s1 == CH_EQ) begin
						fin_kind = (mode_q == M_GT) ? KIND_GE : KIND_LE;
						fin_len  = 33'(len_before) + 33'd1;
						mode_d   = M_IDLE;
					end else begin
						fin_kind = (mode_q == M_GT) ? KIND_GT : KIND_LT;
						use_idle = 1'b1;
					end
				end
				M_NUMBER: begin
					if (char_s1 == CH_DOT) begin
						mode_d = M_AFTER_DOT;
					end else if (!is_digit(char_s1)) begin
						fin_v    = 1'b1;
						use_idle = 1'b1;
					end
				end
				M_AFTER_DOT: begin
					if (is_digit(char_s1)) begin
						mode_d = M_FRACTION;
					end else begin
						fin_v    = 1'b1;
						use_idle = 1'b1;
					end
				end
				M_FRACTION: begin
					if (!is_digit(char_s1)) begin
						fin_v    = 1'b1;
						fin_kind = KIND_FLOAT;
						use_idle = 1'b1;
					end
				end
				M_WORD: begin
					if (is_letter(char_s1)) begin
						for (int i = 0; i < KEYWORD_CHARS; i++) begin
							if (wlen_q == 4'(i)) begin
								wbuf_d[8*i +: 8] = char_s1;
							end
						end
						if (wlen_q <= 4'(KEYWORD_CHARS)) begin
							wlen_d = wlen_q + 4'd1;
						end
					end else begin
						fin_v    = 1'b1;
						fin_kind = word_kind;
						use_idle = 1'b1;
					end
				end
				default: begin
					use_idle = 1'b1;
				end
			endcase
			if (use_idle) begin
				mode_d   = id_mode;
				start_d  = pos_q;
				line_inc = id_line;
				sec_v    = id_tok;
				sec_kind = id_kind;
				sec_len  = 33'd1;
				if (id_word) begin
					wbuf_d        = '0;
					wbuf_d[7:0]   = char_s1;
					wlen_d        = 4'd1;
				end
			end
		end
	end

	always_comb begin
		pair.a_valid  = fire && fin_v;
		pair.a.kind   = fin_kind;
		pair.a.start  = clamp_field(33'(start_q));
		pair.a.length = clamp_field(fin_len);
		pair.a.line   = line_q;
		pair.a.last   = !sec_v;
		pair.b_valid  = fire && sec_v;
		pair.b.kind   = sec_kind;
		pair.b.start  = clamp_field(33'(pos_q));
		pair.b.length = clamp_field(sec_len);
		pair.b.line   = line_q;
		pair.b.last   = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_IDLE;
			pos_q        <= '0;
			start_q      <= '0;
			line_q       <= FIRST_LINE_RESET;
			wbuf_q       <= '0;
			wlen_q       <= '0;
		end else begin
			if (cfg_write) begin
				line_q       <= cfg_first_line;
			end else if (fire && line_inc && line_q != FIELD_MAX) begin
				line_q <= line_q + 20'd1;
			end
			if (fire) begin
				mode_q  <= mode_d;
				start_q <= start_d;
				wbuf_q  <= wbuf_d;
				wlen_q  <= wlen_d;
				if (pos_inc && pos_q != POS_MAX) begin
					pos_q <= pos_q + POSITION_BITS'(1);
				end
			end
		end
	end

endmodule

// ===== rtl/stt_outq.sv =====
module stt_outq import stt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  tok_pair_t pair,
	output logic      room,
	output logic      head_valid,
	input  logic      head_ready,
	output token_t    head
);

	localparam int DEPTH = 4;

	token_t     mem_q [DEPTH];
	logic [1:0] wr_q, rd_q, b_idx;
	logic [2:0] count_q;
	logic [1:0] n_push;
	logic       pop;

	// Room is kept for both tokens that a single word can produce.
	assign room       = count_q <= 3'd2;
	assign head_valid = count_q != 3'd0;
	assign head       = mem_q[rd_q];
	assign pop        = head_valid && head_ready;
	assign n_push     = {1'b0, pair.a_valid} + {1'b0, pair.b_valid};
	assign b_idx      = wr_q + {1'b0, pair.a_valid};

	always_ff @(posedge clk) begin
		if (pair.a_valid) begin
			mem_q[wr_q] <= pair.a;
		end
		if (pair.b_valid) begin
			mem_q[b_idx] <= pair.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + n_push;
			count_q <= count_q + 3'(n_push) - 3'(pop);
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
		end
	end

endmodule

// ===== rtl/source_text_tokenizer_top.sv =====
// A result is offered after its input word passes the input register and the result
// queue; a second result from the same word enters the queue with the first.
// Throughput: one input word per cycle while the result side keeps up; a word
// that ends two tokens yields both, one after the other, on the single result port.
// Reset (arst_n low) returns to the idle scan mode at offset zero with the
// line counter at one.
module source_text_tokenizer_top import stt_pkg::*; #(
	parameter int POSITION_BITS = 20,
	parameter int KEYWORD_CHARS = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [FIELD_BITS-1:0] first_line_number,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            char_byte,
	input  logic                  end_of_text,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [4:0]            token_kind,
	output logic [FIELD_BITS-1:0] token_start,
	output logic [FIELD_BITS-1:0] token_length,
	output logic [FIELD_BITS-1:0] token_line,
	output logic                  last_of_run
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eot_s1;
	logic       room;
	logic       fire;
	tok_pair_t  pair;
	token_t     head;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && room;
	assign in_ready  = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_byte;
			eot_s1  <= end_of_text;
		end
	end

	stt_scan #(
		.POSITION_BITS(POSITION_BITS),
		.KEYWORD_CHARS(KEYWORD_CHARS)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_valid && cfg_ready),
		.cfg_first_line(first_line_number),
		.fire          (fire),
		.char_s1       (char_s1),
		.eot_s1        (eot_s1),
		.pair          (pair)
	);

	stt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair      (pair),
		.room      (room),
		.head_valid(out_valid),
		.head_ready(out_ready),
		.head      (head)
	);

	assign token_kind   = head.kind;
	assign token_start  = head.start;
	assign token_length = head.length;
	assign token_line   = head.line;
	assign last_of_run  = head.last;

endmodule

// ===== sim/tb_source_text_tokenizer_top.sv =====
`timescale 1ns / 100ps

module tb_source_text_tokenizer_top;
	import stt_pkg::*;

	localparam logic [FIELD_BITS-1:0] POS_MAX = FIELD_MAX;

	typedef enum logic [2:0] {
		SCAN_IDLE, SCAN_NUMBER, SCAN_AFTER_DOT, SCAN_FRACTION,
		SCAN_WORD, SCAN_GT, SCAN_LT, SCAN_COMMENT
	} scan_state_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
	} text_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [FIELD_BITS-1:0] first_line_number = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            char_byte = '0;
	logic                  end_of_text = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [4:0]            token_kind;
	logic [FIELD_BITS-1:0] token_start;
	logic [FIELD_BITS-1:0] token_length;
	logic [FIELD_BITS-1:0] token_line;
	logic                  last_of_run;

	source_text_tokenizer_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.first_line_number(first_line_number),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.char_byte        (char_byte),
		.end_of_text      (end_of_text),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.token_kind       (token_kind),
		.token_start      (token_start),
		.token_length     (token_length),
		.token_line       (token_line),
		.last_of_run      (last_of_run)
	);

	string keywords [10] = '{"var", "let", "true", "false", "if", "then", "else", "float",
		"integer", "bool"};
	string punct_set = "+-/*=,;()[]{}";

	// Tokenizer state as the block should hold it.
	scan_state_t           scan_state = SCAN_IDLE;
	logic [FIELD_BITS-1:0] byte_pos = '0;
	logic [FIELD_BITS-1:0] start_pos = '0;
	logic [FIELD_BITS-1:0] line_ctr = FIRST_LINE_RESET;
	logic [55:0]           word_buf = '0;
	int                    word_len = 0;

	token_t     step_tokens [$];
	token_t     expected_tokens [$];
	text_item_t pending_text [$];
	int         queued_items = 0;
	int         mismatch_count = 0;

	logic       no_idle = 1'b0;
	logic       in_taken = 1'b0;
	logic       src_busy = 1'b0;
	int         src_gap = 0;
	text_item_t src_word = '0;
	int         sink_stall = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic logic digit_char(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic letter_char(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic int token_span();
		logic [FIELD_BITS-1:0] d;
		d = byte_pos - start_pos;
		return int'(d);
	endfunction

	function automatic void emit_token(kind_t k, int len);
		token_t t;
		t.kind = k;
		t.start = start_pos;
		t.length = (len > int'(FIELD_MAX)) ? FIELD_MAX : FIELD_BITS'(len);
		t.line = line_ctr;
		t.last = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void count_line();
		if (line_ctr != FIELD_MAX) line_ctr++;
	endfunction

	function automatic kind_t word_class();
		logic [55:0] kw_bits;
		for (int k = 0; k < 10; k++) begin
			if (word_len == keywords[k].len()) begin
				kw_bits = '0;
				for (int i = 0; i < keywords[k].len(); i++) kw_bits[8*i +: 8] = keywords[k][i];
				if (kw_bits == word_buf) return kind_t'(KIND_KW_BASE + k);
			end
		end
		return KIND_IDENT;
	endfunction

	function automatic void idle_byte(logic [7:0] c);
		start_pos = byte_pos;
		if (c == CH_SPACE || c == CH_TAB || c == CH_CR) return;
		if (c == CH_LF) begin
			count_line();
			return;
		end
		if (c == CH_HASH) begin
			scan_state = SCAN_COMMENT;
			return;
		end
		if (c == CH_NUL) begin
			emit_token(KIND_EOF, 1);
			return;
		end
		if (c == CH_GT) begin
			scan_state = SCAN_GT;
			return;
		end
		if (c == CH_LT) begin
			scan_state = SCAN_LT;
			return;
		end
		if (digit_char(c)) begin
			scan_state = SCAN_NUMBER;
			return;
		end
		if (letter_char(c)) begin
			scan_state = SCAN_WORD;
			word_buf = 56'(c);
			word_len = 1;
			return;
		end
		for (int k = 0; k < punct_set.len(); k++) begin
			if (c == punct_set[k]) begin
				emit_token(kind_t'(KIND_PUNCT_BASE + k), 1);
				return;
			end
		end
		emit_token(KIND_ERROR, 1);
	endfunction

	// The byte that ends a token is then taken as the first byte after it.
	function automatic void end_token_then(kind_t k, logic [7:0] c);
		emit_token(k, token_span());
		scan_state = SCAN_IDLE;
		idle_byte(c);
	endfunction

	function automatic void scan_item(logic [7:0] ch, logic eot);
		kind_t  base;
		token_t t;
		step_tokens.delete();
		if (eot) begin
			case (scan_state)
				SCAN_NUMBER, SCAN_AFTER_DOT: emit_token(KIND_INT, token_span());
				SCAN_FRACTION: emit_token(KIND_FLOAT, token_span());
				SCAN_WORD: emit_token(word_class(), token_span());
				SCAN_GT: emit_token(KIND_GT, token_span());
				SCAN_LT: emit_token(KIND_LT, token_span());
				default: ;
			endcase
			scan_state = SCAN_IDLE;
			start_pos = byte_pos;
			emit_token(KIND_EOF, 0);
		end else begin
			case (scan_state)
				SCAN_COMMENT: if (ch == CH_LF) begin
					count_line();
					scan_state = SCAN_IDLE;
				end
				SCAN_GT, SCAN_LT: begin
					base = (scan_state == SCAN_GT) ? KIND_GT : KIND_LT;
					if (ch == CH_EQ) begin
						emit_token(kind_t'(base + 1), token_span() + 1);
						scan_state = SCAN_IDLE;
					end else begin
						end_token_then(base, ch);
					end
				end
				SCAN_NUMBER: begin
					if (ch == CH_DOT) scan_state = SCAN_AFTER_DOT;
					else if (!digit_char(ch)) end_token_then(KIND_INT, ch);
				end
				SCAN_AFTER_DOT: begin
					if (digit_char(ch)) scan_state = SCAN_FRACTION;
					else end_token_then(KIND_INT, ch);
				end
				SCAN_FRACTION: if (!digit_char(ch)) end_token_then(KIND_FLOAT, ch);
				SCAN_WORD: begin
					if (letter_char(ch)) begin
						// Only the first seven letters are kept; the count stops one past that.
						if (word_len < 7) word_buf[8*word_len +: 8] = ch;
						if (word_len <= 7) word_len++;
					end else begin
						end_token_then(word_class(), ch);
					end
				end
				default: idle_byte(ch);
			endcase
			if (byte_pos != POS_MAX) byte_pos++;
		end
		if (step_tokens.size() > 0) begin
			t = step_tokens[step_tokens.size() - 1];
			t.last = 1'b1;
			step_tokens[step_tokens.size() - 1] = t;
			foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void push_byte(logic [7:0] b);
		text_item_t w;
		w.ch = b;
		w.eot = 1'b0;
		pending_text.push_back(w);
		queued_items++;
	endfunction

	function automatic void push_eot();
		text_item_t w;
		w.ch = 8'($urandom_range(0, 255));
		w.eot = 1'b1;
		pending_text.push_back(w);
		queued_items++;
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i]);
	endfunction

	function automatic void push_digits(int n);
		for (int i = 0; i < n; i++) push_byte(8'("0" + $urandom_range(0, 9)));
	endfunction

	function automatic logic [7:0] random_letter();
		if ($urandom_range(0, 1)) return 8'("a" + $urandom_range(0, 25));
		return 8'("A" + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] random_blank();
		case ($urandom_range(0, 3))
			0: return CH_TAB;
			1: return CH_CR;
			2: return CH_LF;
			default: return CH_SPACE;
		endcase
	endfunction

	// Mostly well-formed tokens with random content, run together or apart.
	function automatic void push_random_token();
		string kw;
		int    n;
		case ($urandom_range(0, 19))
			0, 1, 2: push_text(keywords[$urandom_range(0, 9)]);
			3: begin
				kw = keywords[$urandom_range(0, 9)];
				if ($urandom_range(0, 1)) begin
					push_text(kw);
					push_byte(random_letter());
				end else begin
					// Letters differ from their capitals only in bit 5.
					push_byte(kw[0] ^ 8'h20);
					push_text(kw.substr(1, kw.len() - 1));
				end
			end
			4, 5, 6: begin
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++) push_byte(random_letter());
			end
			7, 8: push_digits($urandom_range(1, 5));
			9: begin
				push_digits($urandom_range(1, 4));
				push_byte(CH_DOT);
				push_digits($urandom_range(1, 4));
			end
			10: begin
				push_digits($urandom_range(1, 3));
				push_byte(CH_DOT);
			end
			11, 12: push_byte(punct_set[$urandom_range(0, punct_set.len() - 1)]);
			13: begin
				push_byte($urandom_range(0, 1) ? CH_GT : CH_LT);
				if ($urandom_range(0, 1)) push_byte(CH_EQ);
			end
			14: begin
				push_byte(CH_HASH);
				n = $urandom_range(0, 6);
				for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
				push_byte(CH_LF);
			end
			15: push_byte(random_blank());
			16: push_byte(CH_NUL);
			17: push_byte(8'($urandom_range(0, 255)));
			18: if ($urandom_range(0, 4) == 0) push_eot(); else push_byte(CH_SPACE);
			default: push_byte(CH_DOT);
		endcase
		if ($urandom_range(0, 1)) push_byte(random_blank());
	endfunction

	function automatic void fill_random(int count);
		int goal;
		goal = queued_items + count;
		while (queued_items < goal) push_random_token();
	endfunction

	task automatic wait_drained();
		while (pending_text.size() != 0 || src_busy || expected_tokens.size() != 0)
			@(posedge clk);
		// A word that makes no token may still be in flight.
		repeat (6) @(posedge clk);
	endtask

	task automatic write_first_line(input logic [FIELD_BITS-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		first_line_number <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		line_ctr = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (in_taken) begin
			in_taken = 1'b0;
			src_busy = 1'b0;
			src_gap = pick_gap();
		end
		if (!src_busy && arst_n) begin
			if (src_gap > 0) src_gap--;
			else if (pending_text.size() > 0) begin
				src_word = pending_text.pop_front();
				src_busy = 1'b1;
			end
		end
		in_valid <= src_busy;
		char_byte <= src_word.ch;
		end_of_text <= src_word.eot;
	end

	always @(negedge clk) begin
		if (sink_stall > 0) begin
			sink_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) sink_stall = pick_gap();
		end
	end

	always @(posedge clk) begin : monitor
		token_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_tokens.size() == 0) begin
					report_mismatch($sformatf("token kind %0d with nothing expected", token_kind));
				end else begin
					want = expected_tokens.pop_front();
					if (token_kind !== want.kind)
						report_mismatch($sformatf("token_kind %0d, expected %0d",
							token_kind, want.kind));
					if (token_start !== want.start)
						report_mismatch($sformatf("token_start %0d, expected %0d",
							token_start, want.start));
					if (token_length !== want.length)
						report_mismatch($sformatf("token_length %0d, expected %0d",
							token_length, want.length));
					if (token_line !== want.line)
						report_mismatch($sformatf("token_line %0d, expected %0d",
							token_line, want.line));
					if (last_of_run !== want.last)
						report_mismatch($sformatf("last_of_run %0b, expected %0b",
							last_of_run, want.last));
				end
			end
			if (in_valid && in_ready) begin
				scan_item(char_byte, end_of_text);
				in_taken = 1'b1;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Compares, trailing dot, float, NUL inside a comment, unknown byte, NUL token,
		// end of text inside a comment and end of text flushing a number.
		push_text("if>=9.<2<=3.5");
		push_byte(CH_TAB);
		push_byte(CH_HASH);
		push_byte(CH_NUL);
		push_byte(CH_LF);
		push_byte(8'hFF);
		push_byte(CH_NUL);
		push_byte(CH_CR);
		push_text(" >a#z");
		push_eot();
		push_text("7");
		push_eot();
		fill_random(260);
		wait_drained();

		write_first_line('0);
		fill_random(290);
		wait_drained();

		// Line numbers start at the ceiling, and this phase runs with no idling.
		write_first_line(FIELD_MAX);
		no_idle = 1'b1;
		fill_random(290);
		wait_drained();
		no_idle = 1'b0;

		write_first_line(FIELD_MAX - 1);
		fill_random(290);
		wait_drained();

		write_first_line(FIELD_BITS'($urandom_range(2, int'(FIELD_MAX) - 2)));
		fill_random(290);
		wait_drained();

		write_first_line(FIRST_LINE_RESET);
		fill_random(290);
		wait_drained();

		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/stt_pkg.sv
rtl/stt_scan.sv
rtl/stt_outq.sv
rtl/source_text_tokenizer_top.sv
sim/tb_source_text_tokenizer_top.sv
